FILE: rtl/mev_pkg.sv
package mev_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int PTR_W      = $clog2(2 * RING_DEPTH);
    localparam int OCC_W      = PTR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [15:0] CLIP_MIN_X_RST = 16'sd0;
    localparam logic signed [15:0] CLIP_MAX_X_RST = 16'sd1024;
    localparam logic signed [15:0] CLIP_MIN_Y_RST = 16'sd0;
    localparam logic signed [15:0] CLIP_MAX_Y_RST = 16'sd768;

    typedef enum logic [1:0] {
        CMD_TRACK  = 2'd0,
        CMD_WARP   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_RESIZE = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN = 3'd0,
        CFG_MIN_X  = 3'd1,
        CFG_MAX_X  = 3'd2,
        CFG_MIN_Y  = 3'd3,
        CFG_MAX_Y  = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         buttons;
        logic [31:0]        time_ms;
        logic [31:0]        count;
    } mev_snap_t;

    // Ring slot of a pointer that counts modulo twice the depth.
    function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] t;
        begin
            t = (ptr >= PTR_W'(RING_DEPTH)) ? ptr - PTR_W'(RING_DEPTH) : ptr;
            return t[IDX_W-1:0];
        end
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        begin
            return (ptr == PTR_W'(2 * RING_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
        end
    endfunction

    // Minimum first; an empty rectangle falls through to max minus one.
    function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v,
                                                      input logic signed [15:0] lo,
                                                      input logic signed [15:0] hi);
        logic signed [15:0] t;
        begin
            t = (v < lo) ? lo : v;
            if (t >= hi)
                t = hi - 16'sd1;
            return t;
        end
    endfunction

endpackage

FILE: rtl/mev_ring.sv
module mev_ring (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [mev_pkg::IDX_W-1:0]   wr_addr,
    input  mev_pkg::mev_snap_t          wr_data,
    input  logic [mev_pkg::IDX_W-1:0]   rd_addr,
    output mev_pkg::mev_snap_t          rd_data
);
    import mev_pkg::*;

    mev_snap_t mem [RING_DEPTH];
    mev_snap_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mouse_event_queue.sv
// Track, warp and resize beats leave the block idle, so a new beat can be taken the next cycle.
// A read beat enters the read state: the ring memory read, then the report lands in the
// output register once the output is not stalled. The ring's registered read port sets this.
// Reset (rst_n, asynchronous, active low) clears pointers, counters, current state and
// configuration; ring contents stay undefined and need no clearing pass.
module mouse_event_queue (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mev_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mev_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic signed [15:0]               pos_x,
    input  logic signed [15:0]               pos_y,
    input  logic [7:0]                       button_mask,
    input  logic [31:0]                      time_ms,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             has_report,
    output logic                             resize_flag,
    output logic signed [15:0]               out_x,
    output logic signed [15:0]               out_y,
    output logic [7:0]                       out_buttons,
    output logic [31:0]                      out_time_ms
);
    import mev_pkg::*;

    // Configuration registers.
    logic               screen_present_reg;
    logic signed [15:0] clip_min_x_reg;
    logic signed [15:0] clip_max_x_reg;
    logic signed [15:0] clip_min_y_reg;
    logic signed [15:0] clip_max_y_reg;

    // Pointer state.
    logic signed [15:0] cur_x_reg;
    logic signed [15:0] cur_y_reg;
    logic [7:0]         cur_buttons_reg;
    logic [31:0]        cur_time_reg;
    logic [31:0]        update_count_reg;
    logic [31:0]        seen_count_reg;
    logic               resize_pending_reg;
    logic [PTR_W-1:0]   read_ptr_reg;
    logic [PTR_W-1:0]   write_ptr_reg;

    state_t state_reg;
    state_t state_next;

    // Output register.
    logic               out_valid_reg;
    logic               has_report_reg;
    logic               resize_flag_reg;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic [7:0]         out_buttons_reg;
    logic [31:0]        out_time_reg;

    logic       in_accept;
    logic       out_load;
    logic       track_go;
    logic       snap_go;
    logic       ring_full;
    logic       ring_empty;
    logic       nothing_new;
    logic [OCC_W-1:0] occupancy;
    cmd_t       cmd;
    logic [7:0] new_buttons;
    mev_snap_t  snap_wr;
    mev_snap_t  snap_rd;
    mev_snap_t  report;

    assign cmd       = cmd_t'(command);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_present_reg <= 1'b0;
            clip_min_x_reg     <= CLIP_MIN_X_RST;
            clip_max_x_reg     <= CLIP_MAX_X_RST;
            clip_min_y_reg     <= CLIP_MIN_Y_RST;
            clip_max_y_reg     <= CLIP_MAX_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCREEN: screen_present_reg <= cfg_data[0];
                CFG_MIN_X:  clip_min_x_reg     <= cfg_data;
                CFG_MAX_X:  clip_max_x_reg     <= cfg_data;
                CFG_MIN_Y:  clip_min_y_reg     <= cfg_data;
                CFG_MAX_Y:  clip_max_y_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && cmd == CMD_READ)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State-decoded outputs.
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_READ: out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (write_ptr_reg >= read_ptr_reg)
            occupancy = OCC_W'(write_ptr_reg) - OCC_W'(read_ptr_reg);
        else
            occupancy = OCC_W'(write_ptr_reg) + OCC_W'(2 * RING_DEPTH)
                        - OCC_W'(read_ptr_reg);
    end

    assign ring_full   = (occupancy == OCC_W'(RING_DEPTH));
    assign ring_empty  = (read_ptr_reg == write_ptr_reg);
    assign new_buttons = (cmd == CMD_TRACK) ? button_mask : cur_buttons_reg;
    assign track_go    = in_accept && screen_present_reg
                         && (cmd == CMD_TRACK || cmd == CMD_WARP);
    assign snap_go     = track_go && (new_buttons != cur_buttons_reg) && !ring_full;

    assign snap_wr.x       = clamp_axis(pos_x, clip_min_x_reg, clip_max_x_reg);
    assign snap_wr.y       = clamp_axis(pos_y, clip_min_y_reg, clip_max_y_reg);
    assign snap_wr.buttons = new_buttons;
    assign snap_wr.time_ms = time_ms;
    assign snap_wr.count   = update_count_reg + 32'd1;

    // Writes happen only on track beats and the read address is sampled on the read
    // beat itself, so a read never overlaps a write to the same slot.
    mev_ring u_ring (
        .clk     (clk),
        .wr_en   (snap_go),
        .wr_addr (ptr_idx(write_ptr_reg)),
        .wr_data (snap_wr),
        .rd_addr (ptr_idx(read_ptr_reg)),
        .rd_data (snap_rd)
    );

    assign nothing_new = (seen_count_reg == update_count_reg) && !resize_pending_reg;

    always_comb
    begin
        if (ring_empty)
        begin
            report.x       = cur_x_reg;
            report.y       = cur_y_reg;
            report.buttons = cur_buttons_reg;
            report.time_ms = cur_time_reg;
            report.count   = update_count_reg;
        end
        else
        begin
            report = snap_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cur_x_reg          <= '0;
            cur_y_reg          <= '0;
            cur_buttons_reg    <= '0;
            cur_time_reg       <= '0;
            update_count_reg   <= '0;
            seen_count_reg     <= '0;
            resize_pending_reg <= 1'b0;
            read_ptr_reg       <= '0;
            write_ptr_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (track_go)
            begin
                cur_x_reg        <= snap_wr.x;
                cur_y_reg        <= snap_wr.y;
                cur_buttons_reg  <= new_buttons;
                cur_time_reg     <= time_ms;
                update_count_reg <= snap_wr.count;
            end
            if (snap_go)
                write_ptr_reg <= ptr_next(write_ptr_reg);

            if (in_accept && cmd == CMD_RESIZE)
                resize_pending_reg <= 1'b1;

            if (out_load && !nothing_new)
            begin
                seen_count_reg     <= report.count;
                resize_pending_reg <= 1'b0;
                if (!ring_empty)
                    read_ptr_reg <= ptr_next(read_ptr_reg);
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (nothing_new)
            begin
                has_report_reg  <= 1'b0;
                resize_flag_reg <= 1'b0;
                out_x_reg       <= '0;
                out_y_reg       <= '0;
                out_buttons_reg <= '0;
                out_time_reg    <= '0;
            end
            else
            begin
                has_report_reg  <= 1'b1;
                resize_flag_reg <= resize_pending_reg;
                out_x_reg       <= report.x;
                out_y_reg       <= report.y;
                out_buttons_reg <= report.buttons;
                out_time_reg    <= report.time_ms;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign has_report  = has_report_reg;
    assign resize_flag = resize_flag_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_buttons = out_buttons_reg;
    assign out_time_ms = out_time_reg;

`ifndef NO_ASSERTIONS
    // The ring never holds more snapshots than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OCC_W'(RING_DEPTH))
        else $error("ring occupancy above depth");

    // A read beat always enters the read state on the following edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_READ) |=> (state_reg == ST_READ))
        else $error("read beat did not enter the read state");

    // An empty report carries all-zero fields and no resize.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_report) |-> (!resize_flag && out_x == '0 && out_y == '0
                                        && out_buttons == '0 && out_time_ms == '0))
        else $error("empty report carries data");

    // Snapshots are queued only while a screen is present.
    assert property (@(posedge clk) disable iff (!rst_n)
        snap_go |-> screen_present_reg)
        else $error("snapshot queued without a screen");
`endif

endmodule
